/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the connection engine RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/tce_pkg.sv */
// Types and constants for the TCP connection engine.
// No dependencies; used by every other RTL file except assert_macros.svh.
package tce_pkg;

    localparam logic [15:0] RX_BUF_BYTES  = 16'd16384;
    localparam logic [15:0] TX_BUF_BYTES  = 16'd65535;
    localparam logic [3:0]  BACKOFF_LIMIT = 4'd8;
    localparam logic [7:0]  RETRY_MAX     = 8'd255;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIMEOUT     = 2'd1;
    localparam logic [CFG_W-1:0] INITIAL_TIMEOUT_RST = 20'd1000;
    localparam logic [CFG_W-1:0] MAX_TIMEOUT_RST     = 20'd30000;

    // operation codes
    localparam logic [2:0] OP_RECV  = 3'd0;
    localparam logic [2:0] OP_FLUSH = 3'd1;
    localparam logic [2:0] OP_OPEN  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // receive status codes
    localparam logic [2:0] RX_OK         = 3'd0;
    localparam logic [2:0] RX_RESET      = 3'd1;
    localparam logic [2:0] RX_OUT_ORDER  = 3'd2;
    localparam logic [2:0] RX_BAD_HSHAKE = 3'd3;
    localparam logic [2:0] RX_BAD_STATE  = 3'd4;

    // flag byte bits
    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    // pending mark bits
    localparam logic [2:0] MARK_SYN = 3'b001;
    localparam logic [2:0] MARK_ACK = 3'b010;
    localparam logic [2:0] MARK_FIN = 3'b100;

    typedef enum logic [1:0] {
        MODE_CLOSED   = 2'd0,
        MODE_SYN_SENT = 2'd1,
        MODE_ESTAB    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [7:0]  seg_flags;
        logic [15:0] seg_window;
        logic [15:0] byte_count;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_flags;
        logic [31:0] tx_seq;
        logic [31:0] tx_ack;
        logic [15:0] tx_window;
        logic [15:0] tx_len;
        logic [2:0]  rx_status;
        logic [15:0] rx_accepted;
        logic        rx_fin;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] initial_timeout;
        logic [CFG_W-1:0] max_timeout;
    } cfg_t;

endpackage

/* hw/rtl/tce_item_if.sv */
// Input channel of the connection engine: valid/ready plus one operation.
// Depends on tce_pkg.
interface tce_item_if;
    logic            valid;
    logic            ready;
    tce_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tce_result_if.sv */
// Result channel of the connection engine: valid/ready plus one result.
// Depends on tce_pkg.
interface tce_result_if;
    logic              valid;
    logic              ready;
    tce_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tce_cfg_regs.sv */
// Retransmit timing configuration registers, written through a plain port.
// Depends on tce_pkg.
module tce_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]     cfg_wdata,
    output tce_pkg::cfg_t                 cfg
);

    logic [tce_pkg::CFG_W-1:0] init_to_reg;
    logic [tce_pkg::CFG_W-1:0] max_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_to_reg <= tce_pkg::INITIAL_TIMEOUT_RST;
            max_to_reg  <= tce_pkg::MAX_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tce_pkg::CFG_INITIAL_TIMEOUT)
                init_to_reg <= cfg_wdata;
            if (cfg_index == tce_pkg::CFG_MAX_TIMEOUT)
                max_to_reg <= cfg_wdata;
        end
    end

    assign cfg.initial_timeout = init_to_reg;
    assign cfg.max_timeout     = max_to_reg;

endmodule

/* hw/rtl/tce_conn_core.sv */
// Connection state registers and the combinational update for one operation.
// Depends on tce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tce_conn_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tce_pkg::item_t   din,
    input  tce_pkg::cfg_t    cfg,
    output tce_pkg::result_t res
);

    tce_pkg::mode_t mode_reg, mode_next;
    logic [2:0]  marks_reg, marks_next;
    logic [31:0] send_next_reg, send_next_next;
    logic [31:0] last_sent_reg, last_sent_next;
    logic [31:0] recv_next_reg, recv_next_next;
    logic [15:0] local_win_reg, local_win_next;
    logic [15:0] peer_win_reg, peer_win_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [7:0]  retry_cnt_reg, retry_cnt_next;
    logic [15:0] tx_queued_reg, tx_queued_next;

    // receive path helpers
    logic        seg_rst, seg_fin, seg_syn_ack, seq_ok;
    logic [31:0] acked;
    logic [15:0] queued_after_ack;
    logic        rx_take;
    logic [15:0] rx_len;
    logic [31:0] recv_after_data;

    // flush path helpers
    logic        timer_wait;
    logic [15:0] flen;
    logic        retry_bump;
    logic [7:0]  retry_flush;
    logic [7:0]  fflags;
    logic [3:0]  shamt;
    logic [27:0] delay_full;
    logic [19:0] delay;

    // app write/read helpers
    logic [16:0] wr_sum;
    logic [15:0] rx_fill;
    logic [15:0] rd_len;

    assign seg_rst     = (din.seg_flags & tce_pkg::FL_RST) != 8'd0;
    assign seg_fin     = (din.seg_flags & tce_pkg::FL_FIN) != 8'd0;
    assign seg_syn_ack = (din.seg_flags & (tce_pkg::FL_SYN | tce_pkg::FL_ACK)) != 8'd0;
    assign seq_ok      = din.seg_seq == recv_next_reg;

    assign acked = din.seg_ack - send_next_reg;
    assign queued_after_ack = (acked >= {16'd0, tx_queued_reg}) ? 16'd0
                            : tx_queued_reg - acked[15:0];
    assign rx_take = (din.byte_count != 16'd0) && (din.byte_count <= local_win_reg);
    assign rx_len  = rx_take ? din.byte_count : 16'd0;
    assign recv_after_data = recv_next_reg + {16'd0, rx_len};

    assign timer_wait = (deadline_reg != 32'd0) && (din.now < deadline_reg);
    assign flen = (mode_reg != tce_pkg::MODE_ESTAB) ? 16'd0
                : (tx_queued_reg < peer_win_reg) ? tx_queued_reg : peer_win_reg;
    assign retry_bump = (mode_reg == tce_pkg::MODE_ESTAB) && (last_sent_reg == send_next_reg)
                      && (retry_cnt_reg != tce_pkg::RETRY_MAX);
    assign retry_flush = retry_cnt_reg + {7'd0, retry_bump};
    assign fflags = ((flen != 16'd0) ? (tce_pkg::FL_ACK | tce_pkg::FL_PSH) : 8'd0)
                  | (marks_reg[0] ? tce_pkg::FL_SYN : 8'd0)
                  | (marks_reg[1] ? tce_pkg::FL_ACK : 8'd0)
                  | (marks_reg[2] ? tce_pkg::FL_FIN : 8'd0);
    assign shamt = (retry_flush < {4'd0, tce_pkg::BACKOFF_LIMIT}) ? retry_flush[3:0]
                 : tce_pkg::BACKOFF_LIMIT;
    assign delay_full = {8'd0, cfg.initial_timeout} << shamt;
    assign delay = (delay_full > {8'd0, cfg.max_timeout}) ? cfg.max_timeout
                 : delay_full[19:0];

    assign wr_sum  = {1'b0, tx_queued_reg} + {1'b0, din.byte_count};
    assign rx_fill = (local_win_reg >= tce_pkg::RX_BUF_BYTES) ? 16'd0
                   : tce_pkg::RX_BUF_BYTES - local_win_reg;
    assign rd_len  = (din.byte_count < rx_fill) ? din.byte_count : rx_fill;

    // connection mode transitions
    always_comb
    begin
        mode_next = mode_reg;
        if (fire)
        begin
            case (din.op)
                tce_pkg::OP_RECV:
                begin
                    if (!seg_rst)
                    begin
                        if (mode_reg == tce_pkg::MODE_SYN_SENT && seg_syn_ack)
                            mode_next = tce_pkg::MODE_ESTAB;
                        else if (mode_reg == tce_pkg::MODE_ESTAB && seq_ok && seg_fin)
                            mode_next = tce_pkg::MODE_CLOSED;
                    end
                end
                tce_pkg::OP_OPEN:  mode_next = tce_pkg::MODE_SYN_SENT;
                tce_pkg::OP_CLOSE: mode_next = tce_pkg::MODE_CLOSED;
                default:           mode_next = mode_reg;
            endcase
        end
    end

    // remaining state and the result
    always_comb
    begin
        marks_next     = marks_reg;
        send_next_next = send_next_reg;
        last_sent_next = last_sent_reg;
        recv_next_next = recv_next_reg;
        local_win_next = local_win_reg;
        peer_win_next  = peer_win_reg;
        deadline_next  = deadline_reg;
        retry_cnt_next = retry_cnt_reg;
        tx_queued_next = tx_queued_reg;
        res            = '0;

        case (din.op)
            tce_pkg::OP_RECV:
            begin
                res.kind = tce_pkg::KIND_REPORT;
                if (seg_rst)
                    res.rx_status = tce_pkg::RX_RESET;
                else if (mode_reg != tce_pkg::MODE_SYN_SENT && !seq_ok)
                begin
                    marks_next    = marks_reg | tce_pkg::MARK_ACK;
                    res.rx_status = tce_pkg::RX_OUT_ORDER;
                end
                else
                begin
                    peer_win_next = din.seg_window;
                    case (mode_reg)
                        tce_pkg::MODE_SYN_SENT:
                        begin
                            if (!seg_syn_ack)
                                res.rx_status = tce_pkg::RX_BAD_HSHAKE;
                            else
                            begin
                                send_next_next = din.seg_ack;
                                recv_next_next = din.seg_seq + 32'd1;
                                deadline_next  = 32'd0;
                                marks_next     = marks_reg | tce_pkg::MARK_ACK;
                            end
                        end
                        tce_pkg::MODE_ESTAB:
                        begin
                            if (acked != 32'd0)
                            begin
                                tx_queued_next = queued_after_ack;
                                send_next_next = din.seg_ack;
                            end
                            recv_next_next  = recv_after_data;
                            local_win_next  = local_win_reg - rx_len;
                            res.rx_accepted = rx_len;
                            if (rx_take || seg_fin)
                                marks_next = marks_reg | tce_pkg::MARK_ACK;
                            if (seg_fin)
                            begin
                                deadline_next  = 32'd0;
                                recv_next_next = recv_after_data + 32'd1;
                                res.rx_fin     = 1'b1;
                            end
                        end
                        default: res.rx_status = tce_pkg::RX_BAD_STATE;
                    endcase
                end
            end
            tce_pkg::OP_FLUSH:
            begin
                if (!timer_wait)
                begin
                    peer_win_next  = peer_win_reg - flen;
                    retry_cnt_next = retry_flush;
                    if (fflags != 8'd0)
                    begin
                        res.kind      = tce_pkg::KIND_TX;
                        res.tx_flags  = fflags;
                        res.tx_seq    = send_next_reg;
                        res.tx_ack    = ((fflags & tce_pkg::FL_ACK) != 8'd0) ? recv_next_reg
                                      : 32'd0;
                        res.tx_window = local_win_reg;
                        res.tx_len    = flen;
                        deadline_next  = din.now + {12'd0, delay};
                        last_sent_next = send_next_reg;
                        marks_next     = 3'd0;
                    end
                end
            end
            tce_pkg::OP_OPEN, tce_pkg::OP_CLOSE:
            begin
                marks_next     = (din.op == tce_pkg::OP_OPEN) ? tce_pkg::MARK_SYN : 3'd0;
                send_next_next = 32'd0;
                last_sent_next = 32'd0;
                recv_next_next = 32'd0;
                local_win_next = tce_pkg::RX_BUF_BYTES;
                peer_win_next  = 16'd0;
                deadline_next  = 32'd0;
                retry_cnt_next = 8'd0;
                tx_queued_next = 16'd0;
            end
            tce_pkg::OP_WRITE:
            begin
                tx_queued_next = (wr_sum > {1'b0, tce_pkg::TX_BUF_BYTES}) ? tce_pkg::TX_BUF_BYTES
                               : wr_sum[15:0];
                deadline_next  = 32'd0;
            end
            tce_pkg::OP_READ:
                local_win_next = local_win_reg + rd_len;
            default:
                res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tce_pkg::MODE_CLOSED;
            marks_reg     <= 3'd0;
            send_next_reg <= 32'd0;
            last_sent_reg <= 32'd0;
            recv_next_reg <= 32'd0;
            local_win_reg <= tce_pkg::RX_BUF_BYTES;
            peer_win_reg  <= 16'd0;
            deadline_reg  <= 32'd0;
            retry_cnt_reg <= 8'd0;
            tx_queued_reg <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            marks_reg     <= marks_next;
            send_next_reg <= send_next_next;
            last_sent_reg <= last_sent_next;
            recv_next_reg <= recv_next_next;
            local_win_reg <= local_win_next;
            peer_win_reg  <= peer_win_next;
            deadline_reg  <= deadline_next;
            retry_cnt_reg <= retry_cnt_next;
            tx_queued_reg <= tx_queued_next;
        end
    end

    // local receive window never exceeds the buffer size
    `ASSERT_NEVER(a_local_win_bound, clk, rst_n, local_win_reg > tce_pkg::RX_BUF_BYTES, "local window above buffer size")
    // open always lands in syn-sent with only SYN pending and no timer
    `ASSERT_CLK(a_open_state, clk, rst_n, (fire && din.op == tce_pkg::OP_OPEN) |=> (mode_reg == tce_pkg::MODE_SYN_SENT && marks_reg == tce_pkg::MARK_SYN && deadline_reg == 32'd0), "open did not re-initialize")
    // a transmitted segment clears all pending marks
    `ASSERT_CLK(a_tx_clears_marks, clk, rst_n, (fire && res.kind == tce_pkg::KIND_TX) |=> (marks_reg == 3'd0), "marks left after transmit")

endmodule

/* hw/rtl/tce_result_reg.sv */
// Output register of the result channel; loads when the core completes an item.
// Depends on tce_pkg, tce_result_if and assert_macros.svh.
`include "assert_macros.svh"

module tce_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tce_pkg::result_t din,
    output logic             can_load,
    tce_result_if.source     result
);

    logic             valid_reg, valid_next;
    tce_pkg::result_t data_reg;

    assign can_load = !valid_reg || result.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign result.valid = valid_reg;
    assign result.data  = data_reg;

    // a load is only issued when the slot is free or draining
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, load && valid_reg && !result.ready, "result overwritten before transfer")

endmodule

/* hw/rtl/tcp_connection_engine_unit.sv */
// TCP connection engine: one operation per transaction, one result per operation.
// Path: an accepted operation waits in the input register until the result register
// can load; the combinational state update then writes the result register.
// Throughput: one operation per cycle unless result back-pressure stalls; the state update is combinational.
// Reset: asynchronous, active low; connection closed, timeouts 1000 and 30000.
module tcp_connection_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    tce_item_if.sink                      item,
    tce_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]     cfg_wdata
);

    logic             in_valid_reg, in_valid_next;
    tce_pkg::item_t   in_data_reg;
    logic             can_load;
    logic             fire;
    logic             accept;
    tce_pkg::cfg_t    cfg;
    tce_pkg::result_t core_res;

    assign fire       = in_valid_reg && can_load;
    assign item.ready = !in_valid_reg || fire;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= item.data;
    end

    tce_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tce_conn_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .din   (in_data_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    tce_result_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .din      (core_res),
        .can_load (can_load),
        .result   (result)
    );

endmodule
